// ===== design/pcc_pkg.sv =====
// Shared widths, constants, the CORDIC stage record and the arctangent constant function for the converter.
package pcc_pkg;

  localparam int COORD_W           = 32;
  localparam int XW                = 50;  // CORDIC x/y, Q.32 plus guard bits
  localparam int ZW                = 36;  // CORDIC angle, Q.30 plus guard bits
  localparam int ATW               = 31;  // width of one arctangent constant
  localparam int CORDIC_STAGES_DEF = 24;

  localparam logic [31:0]          GAIN_Q32       = 32'h9B74EDA8;
  localparam logic signed [ZW-1:0] PI_Q30         = 36'sd3373259426;
  localparam logic signed [ZW-1:0] PI2_Q30        = 36'sd6746518852;
  localparam logic signed [ZW-1:0] HALF_PI_Q30    = 36'sd1686629713;
  localparam logic signed [ZW-1:0] QUARTER_PI_Q30 = 36'sd843314857;
  localparam logic [31:0]          PI2_Q28        = 32'd1686629713;

  typedef struct packed {
    logic                 mode;   // 0 rotate, 1 vector
    logic                 flip;   // rotate: negate result; vector: input at origin
    logic                 ysign;  // vector: sign of the original y
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } pcc_cordic_t;

  // One term of the arctangent series: v / (2k + 1).
  function automatic logic [63:0] series_term(input int k, input logic [63:0] v);
    logic [63:0] t;
    case (k)
      0:       t = v;
      1:       t = v / 3;
      2:       t = v / 5;
      3:       t = v / 7;
      4:       t = v / 9;
      5:       t = v / 11;
      6:       t = v / 13;
      7:       t = v / 15;
      8:       t = v / 17;
      9:       t = v / 19;
      10:      t = v / 21;
      11:      t = v / 23;
      12:      t = v / 25;
      13:      t = v / 27;
      14:      t = v / 29;
      15:      t = v / 31;
      16:      t = v / 33;
      17:      t = v / 35;
      18:      t = v / 37;
      19:      t = v / 39;
      20:      t = v / 41;
      21:      t = v / 43;
      22:      t = v / 45;
      23:      t = v / 47;
      24:      t = v / 49;
      25:      t = v / 51;
      26:      t = v / 53;
      27:      t = v / 55;
      28:      t = v / 57;
      29:      t = v / 59;
      default: t = '0;
    endcase
    return t;
  endfunction

  // atan(2^-idx) in Q.30, summed in Q.60 and rounded; evaluated at elaboration.
  function automatic logic [ATW-1:0] atan_q30(input int idx);
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] rnd;
    int          e;
    sum = '0;
    if (idx == 0) begin
      rnd = 64'(QUARTER_PI_Q30);
    end else begin
      for (int k = 0; k < 30; k++) begin
        e = idx * (2 * k + 1);
        if (e <= 60) begin
          term = series_term(k, 64'd1 << (60 - e));
          if ((k & 1) != 0) sum = sum - term;
          else sum = sum + term;
        end
      end
      rnd = (sum + (64'd1 << 29)) >> 30;
    end
    return rnd[ATW-1:0];
  endfunction

endpackage

// ===== design/pcc_in_if.sv =====
// Input channel: one point per item with its conversion mode.
interface pcc_in_if import pcc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic signed [COORD_W-1:0] coord_a;
  logic signed [COORD_W-1:0] coord_b;

  modport source(output valid, mode, coord_a, coord_b, input ready);
  modport sink(input valid, mode, coord_a, coord_b, output ready);
endinterface

// ===== design/pcc_out_if.sv =====
// Output channel: one converted point per item and its saturation flag.
interface pcc_out_if import pcc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] out_a;
  logic signed [COORD_W-1:0] out_b;
  logic                      saturated;

  modport source(output valid, out_a, out_b, saturated, input ready);
  modport sink(input valid, out_a, out_b, saturated, output ready);
endinterface

// ===== design/pcc_cordic_stage.sv =====
// One registered CORDIC micro-rotation with its own valid bit and bubble-collapsing ready.
module pcc_cordic_stage import pcc_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        load,
  input  pcc_cordic_t in_data,
  output logic        out_valid,
  input  logic        down_load,
  output pcc_cordic_t out_data
);

  localparam logic signed [ZW-1:0] ATAN = $signed({{(ZW-ATW){1'b0}}, atan_q30(STEP)});

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic                 ccw;
  pcc_cordic_t          data_next;

  // Rotate towards z = 0 in rotation mode, towards y = 0 in vectoring mode.
  always_comb begin
    dx        = in_data.y >>> STEP;
    dy        = in_data.x >>> STEP;
    ccw       = in_data.mode ? in_data.y[XW-1] : !in_data.z[ZW-1];
    data_next = in_data;
    if (ccw) begin
      data_next.x = in_data.x - dx;
      data_next.y = in_data.y + dy;
      data_next.z = in_data.z - ATAN;
    end else begin
      data_next.x = in_data.x + dx;
      data_next.y = in_data.y - dy;
      data_next.z = in_data.z + ATAN;
    end
  end

  assign load = !out_valid || down_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== design/polar_cartesian_converter_core.sv =====
// Polar/Cartesian converter: unrolled CORDIC pipeline, one point per cycle unless stalled.
//
// Each item is one 2-D point. With mode 0 the block takes a radius (Q16.16) and an angle
// (Q4.28 radians, any value, reduced modulo 2*pi) and returns x = r cos t and y = r sin t
// in Q16.16, each clamped to the signed 32-bit range with saturated set on a clamp. With
// mode 1 it takes x and y (Q16.16) and returns the radius (Q16.16, clamped to 0x7FFFFFFF
// with saturated set) and the angle in [0, 2*pi) as Q4.28; the origin gives radius 0 and
// angle 0. Every narrowing rounds half up. A new item is accepted in every cycle unless the
// output stalls, and each item passes through these registers in order: one for the gain
// multiply and angle reduction, one for rounding and quadrant folding, one per CORDIC
// micro-rotation, one for the radius gain multiply and angle clamp, and one for the final
// rounding and saturation, which is also the output register. Every stage has its own
// valid bit and takes a new item whenever it is empty or its content moves on, so a stall
// at the output fills bubbles first and only then holds the input.
module polar_cartesian_converter_core import pcc_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input logic       clk,
  input logic       rst,
  pcc_in_if.sink    point,
  pcc_out_if.source result
);

  localparam int N      = CORDIC_STAGES;
  localparam int DEPTH  = N + 4;
  localparam int OCC_W  = $clog2(DEPTH + 1);
  localparam int XRW    = XW - 16;      // rounded CORDIC coordinate
  localparam int CW     = XRW + 1;      // after optional negation
  localparam int HIW    = XW - 1 - 16;  // upper part of the vector length
  localparam int PHW    = HIW + 32;
  localparam int AGW    = 33;           // clamped angle, Q.30 unsigned
  localparam logic signed [ZW-1:0] PI4_Q30 = PI2_Q30 + PI2_Q30;

  // ---------------------------------------------------------------------------------------
  // Stage 0: gain multiply and angle reduction (rotate); fix-up of the left half (vector)
  // ---------------------------------------------------------------------------------------
  logic                 v_s0;
  logic                 s0_load;
  logic                 s0_mode;
  logic signed [63:0]   s0_prod;
  logic signed [XW-1:0] s0_x;
  logic signed [XW-1:0] s0_y;
  logic signed [ZW-1:0] s0_z;
  logic                 s0_origin;
  logic                 s0_ysign;

  logic signed [64:0]   prod_full;
  logic signed [ZW-1:0] z_raw;
  logic signed [ZW-1:0] z_m2;
  logic signed [ZW-1:0] z_m4;
  logic signed [ZW-1:0] z_p2;
  logic signed [ZW-1:0] z_p4;
  logic signed [ZW-1:0] z_red;
  logic signed [ZW-1:0] z_init;
  logic signed [32:0]   xin;
  logic signed [32:0]   yin;
  logic signed [32:0]   x_abs;
  logic signed [32:0]   y_adj;

  always_comb begin
    prod_full = 65'($signed(point.coord_a)) * 65'($signed({1'b0, GAIN_Q32}));

    // Fold any Q4.28 angle into [-pi, pi) in one step: pick the candidate in range.
    z_raw = {{(ZW-34){point.coord_b[31]}}, point.coord_b, 2'b00};
    z_m2  = z_raw - PI2_Q30;
    z_m4  = z_raw - PI4_Q30;
    z_p2  = z_raw + PI2_Q30;
    z_p4  = z_raw + PI4_Q30;
    if (z_raw >= PI_Q30) begin
      z_red = (z_m2 < PI_Q30) ? z_m2 : z_m4;
    end else if (z_raw < -PI_Q30) begin
      z_red = (z_p2 >= -PI_Q30) ? z_p2 : z_p4;
    end else begin
      z_red = z_raw;
    end

    // Mirror a point in the left half-plane and start the angle at +pi or -pi.
    xin   = {point.coord_a[31], point.coord_a};
    yin   = {point.coord_b[31], point.coord_b};
    x_abs = point.coord_a[31] ? -xin : xin;
    y_adj = point.coord_a[31] ? -yin : yin;
    if (point.coord_a[31]) begin
      z_init = point.coord_b[31] ? -PI_Q30 : PI_Q30;
    end else begin
      z_init = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s0 <= 1'b0;
    end else if (s0_load) begin
      v_s0 <= point.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_load && point.valid) begin
      s0_mode   <= point.mode;
      s0_prod   <= prod_full[63:0];
      s0_x      <= {{(XW-49){x_abs[32]}}, x_abs, 16'h0000};
      s0_y      <= {{(XW-49){y_adj[32]}}, y_adj, 16'h0000};
      s0_z      <= point.mode ? z_init : z_red;
      s0_origin <= (point.coord_a == '0) && (point.coord_b == '0);
      s0_ysign  <= point.coord_b[31];
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 1 (rotate only): round scaled radius, fold the angle into [-pi/2, pi/2]
  // ---------------------------------------------------------------------------------------
  pcc_cordic_t          c [0:N];
  logic [N:0]           cv;
  logic [N+1:0]         ct;
  logic                 cv0;
  pcc_cordic_t          c0;
  pcc_cordic_t          c0_next;
  logic signed [63:0]   pr;

  always_comb begin
    pr      = s0_prod + 64'sd32768;
    c0_next = '0;
    c0_next.mode = s0_mode;
    if (s0_mode) begin
      c0_next.x     = s0_x;
      c0_next.y     = s0_y;
      c0_next.z     = s0_z;
      c0_next.flip  = s0_origin;
      c0_next.ysign = s0_ysign;
    end else begin
      c0_next.x = {{(XW-48){pr[63]}}, pr[63:16]};
      c0_next.y = '0;
      if (s0_z > HALF_PI_Q30) begin
        c0_next.z    = s0_z - PI_Q30;
        c0_next.flip = 1'b1;
      end else if (s0_z < -HALF_PI_Q30) begin
        c0_next.z    = s0_z + PI_Q30;
        c0_next.flip = 1'b1;
      end else begin
        c0_next.z    = s0_z;
        c0_next.flip = 1'b0;
      end
    end
  end

  assign ct[0]   = !cv0 || ct[1];
  assign s0_load = !v_s0 || ct[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cv0 <= 1'b0;
    end else if (ct[0]) begin
      cv0 <= v_s0;
    end
  end

  always_ff @(posedge clk) begin
    if (ct[0] && v_s0) begin
      c0 <= c0_next;
    end
  end

  assign cv[0] = cv0;
  assign c[0]  = c0;

  // ---------------------------------------------------------------------------------------
  // CORDIC micro-rotations, one register stage each
  // ---------------------------------------------------------------------------------------
  for (genvar i = 0; i < N; i++) begin : g_stage
    pcc_cordic_stage #(.STEP(i)) u_stage (
      .clk      (clk),
      .rst      (rst),
      .in_valid (cv[i]),
      .load     (ct[i+1]),
      .in_data  (c[i]),
      .out_valid(cv[i+1]),
      .down_load(ct[i+2]),
      .out_data (c[i+1])
    );
  end

  // ---------------------------------------------------------------------------------------
  // Post stage 1: round x/y (rotate); gain multiply and angle clamp (vector)
  // ---------------------------------------------------------------------------------------
  logic                  v_p1;
  logic                  p1_load;
  logic                  p2_load;
  logic                  p1_mode;
  logic                  p1_flip;
  logic signed [XRW-1:0] p1_xr;
  logic signed [XRW-1:0] p1_yr;
  logic [PHW-1:0]        p1_phi;
  logic [31:0]           p1_plo;
  logic [AGW-1:0]        p1_ang;

  logic signed [XW-1:0]  xs;
  logic signed [XW-1:0]  ys;
  logic [XW-2:0]         ux;
  logic [PHW-1:0]        phi;
  logic [47:0]           lo_prod;
  logic signed [ZW-1:0]  at;
  logic signed [ZW-1:0]  a_lo;
  logic signed [ZW-1:0]  a_hi;
  logic signed [ZW-1:0]  a_cl;

  always_comb begin
    xs      = c[N].x + XW'(32768);
    ys      = c[N].y + XW'(32768);
    ux      = c[N].x[XW-1] ? '0 : c[N].x[XW-2:0];
    phi     = PHW'(ux[XW-2:16]) * PHW'(GAIN_Q32);
    lo_prod = 48'(ux[15:0]) * 48'(GAIN_Q32);
    // Keep the angle within the half-plane picked by the sign of the original y.
    if (c[N].ysign) begin
      at   = c[N].z + PI2_Q30;
      a_lo = PI_Q30;
      a_hi = PI2_Q30 - ZW'(1);
    end else begin
      at   = c[N].z;
      a_lo = '0;
      a_hi = PI_Q30;
    end
    if (at < a_lo) a_cl = a_lo;
    else if (at > a_hi) a_cl = a_hi;
    else a_cl = at;
  end

  assign p1_load = !v_p1 || p2_load;
  assign ct[N+1] = p1_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_p1 <= 1'b0;
    end else if (p1_load) begin
      v_p1 <= cv[N];
    end
  end

  always_ff @(posedge clk) begin
    if (p1_load && cv[N]) begin
      p1_mode <= c[N].mode;
      p1_flip <= c[N].flip;
      p1_xr   <= xs[XW-1:16];
      p1_yr   <= ys[XW-1:16];
      p1_phi  <= phi;
      p1_plo  <= lo_prod[47:16];
      p1_ang  <= a_cl[AGW-1:0];
    end
  end

  // ---------------------------------------------------------------------------------------
  // Post stage 2: negate and saturate (rotate); round and clamp radius and angle (vector)
  // ---------------------------------------------------------------------------------------
  logic                 v_p2;
  logic                 p2_mode;
  logic [31:0]          p2_a;
  logic [31:0]          p2_b;
  logic                 p2_sat;

  logic signed [CW-1:0] nx;
  logic signed [CW-1:0] ny;
  logic                 x_ovf;
  logic                 y_ovf;
  logic [65:0]          rsum;
  logic [33:0]          rad;
  logic [33:0]          asum;
  logic [31:0]          a4;
  logic [31:0]          a_next;
  logic [31:0]          b_next;
  logic                 sat_next;

  always_comb begin
    nx    = p1_flip ? -$signed({p1_xr[XRW-1], p1_xr}) : $signed({p1_xr[XRW-1], p1_xr});
    ny    = p1_flip ? -$signed({p1_yr[XRW-1], p1_yr}) : $signed({p1_yr[XRW-1], p1_yr});
    x_ovf = !((&nx[CW-1:31]) || !(|nx[CW-1:31]));
    y_ovf = !((&ny[CW-1:31]) || !(|ny[CW-1:31]));
    rsum  = 66'(p1_phi) + 66'(p1_plo) + 66'(33'h080000000);
    rad   = rsum[65:32];
    asum  = 34'(p1_ang) + 34'd2;
    a4    = asum[33:2];
    if (p1_mode) begin
      if (p1_flip) begin
        // origin: radius and angle both zero
        a_next   = '0;
        b_next   = '0;
        sat_next = 1'b0;
      end else begin
        sat_next = |rad[33:31];
        a_next   = sat_next ? 32'h7FFFFFFF : rad[31:0];
        b_next   = (a4 > PI2_Q28 - 32'd1) ? PI2_Q28 - 32'd1 : a4;
      end
    end else begin
      a_next   = x_ovf ? (nx[CW-1] ? 32'h80000000 : 32'h7FFFFFFF) : nx[31:0];
      b_next   = y_ovf ? (ny[CW-1] ? 32'h80000000 : 32'h7FFFFFFF) : ny[31:0];
      sat_next = x_ovf || y_ovf;
    end
  end

  assign p2_load = !v_p2 || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_p2 <= 1'b0;
    end else if (p2_load) begin
      v_p2 <= v_p1;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_load && v_p1) begin
      p2_mode <= p1_mode;
      p2_a    <= a_next;
      p2_b    <= b_next;
      p2_sat  <= sat_next;
    end
  end

  assign point.ready      = s0_load;
  assign result.valid     = v_p2;
  assign result.out_a     = $signed(p2_a);
  assign result.out_b     = $signed(p2_b);
  assign result.saturated = p2_sat;

  // ---------------------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------------------
  logic [OCC_W-1:0] occ;
  logic [DEPTH-1:0] vvec;

  assign vvec = {v_s0, cv, v_p1, v_p2};

  // Count items in flight: accepted minus delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ + OCC_W'(point.valid && point.ready) - OCC_W'(result.valid && result.ready);
    end
  end

  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    occ == OCC_W'($countones(vvec)))
    else $error("items in flight do not match stage valid bits");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    point.ready |-> (!(&vvec) || result.ready))
    else $error("input taken while every stage is full and the output is stalled");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    (v_p2 && p2_mode) |-> (p2_b < PI2_Q28))
    else $error("polar angle outside [0, 2pi)");

  a_radius_clamp: assert property (@(posedge clk) disable iff (rst)
    (v_p2 && p2_mode && p2_sat) |-> (p2_a == 32'h7FFFFFFF))
    else $error("saturated radius not at its maximum");

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the polar/Cartesian CORDIC converter: directed table, then random points.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pcc_pkg::*;

  localparam int STAGES       = CORDIC_STAGES_DEF;
  // Cycles with no handshake on either side before the run is declared hung.
  localparam int QUIET_LIMIT  = 2000;
  // Settle time after the last result.
  localparam int DRAIN_CYCLES = STAGES + 12;

  // Handy operand values: unit radius in Q16.16, angles in Q4.28 radians.
  localparam logic [31:0] ONE_Q16   = 32'h0001_0000;
  localparam logic [31:0] T_HALF_PI = 32'd421657428;
  localparam logic [31:0] T_PI      = 32'd843314857;
  localparam logic [31:0] T_TWO_PI  = 32'd1686629713;

  typedef enum logic {
    TO_CARTESIAN = 1'b0,
    TO_POLAR     = 1'b1
  } conv_mode_t;

  typedef struct packed {
    logic [COORD_W-1:0] a;
    logic [COORD_W-1:0] b;
    logic               sat;
  } conv_result_t;

  // One stimulus row; known marks a row whose result is typed in by hand.
  typedef struct packed {
    conv_mode_t   mode;
    logic [31:0]  a;
    logic [31:0]  b;
    logic         known;
    conv_result_t res;
  } point_row_t;

  localparam conv_result_t ZERO_POINT = '0;

  logic clk;
  logic rst;

  pcc_in_if  point_if ();
  pcc_out_if result_if ();

  polar_cartesian_converter_core #(
    .CORDIC_STAGES(STAGES)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .point (point_if),
    .result(result_if)
  );

  conv_result_t results_due[$];  // predicted results, oldest first
  conv_result_t next_due;        // prediction for the item now on the input
  int           errors      = 0;
  int           quiet_cycles = 0;
  int           idle_pct    = 0; // idling intensity for both sides, 0 disables it

  // Directed points: extremes, axes, angle wrap, negative radius, radius overflow.
  point_row_t directed_rows [25] = '{
    // origin in vector mode: radius and angle both forced to zero
    '{TO_POLAR,     32'h0000_0000, 32'h0000_0000, 1'b1, ZERO_POINT},
    // zero radius stays at the origin whatever the angle
    '{TO_CARTESIAN, 32'h0000_0000, 32'h0000_0000, 1'b1, ZERO_POINT},
    '{TO_CARTESIAN, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1, ZERO_POINT},
    '{TO_CARTESIAN, 32'h0000_0000, 32'h8000_0000, 1'b1, ZERO_POINT},
    // unit radius on each axis
    '{TO_CARTESIAN, ONE_Q16,       32'h0000_0000, 1'b0, ZERO_POINT},
    '{TO_CARTESIAN, ONE_Q16,       T_HALF_PI,     1'b0, ZERO_POINT},
    '{TO_CARTESIAN, ONE_Q16,       T_PI,          1'b0, ZERO_POINT},
    '{TO_CARTESIAN, ONE_Q16,       -T_HALF_PI,    1'b0, ZERO_POINT},
    // a full turn, and the most positive and most negative angles
    '{TO_CARTESIAN, ONE_Q16,       T_TWO_PI,      1'b0, ZERO_POINT},
    '{TO_CARTESIAN, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, ZERO_POINT},
    '{TO_CARTESIAN, 32'h8000_0000, 32'h8000_0000, 1'b0, ZERO_POINT},
    // largest radii on the x axis: rounding may clamp
    '{TO_CARTESIAN, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, ZERO_POINT},
    '{TO_CARTESIAN, 32'h8000_0000, 32'h0000_0000, 1'b0, ZERO_POINT},
    // negative radius mirrors the point through the origin
    '{TO_CARTESIAN, -ONE_Q16,      32'h1000_0000, 1'b0, ZERO_POINT},
    // vector mode on the axes
    '{TO_POLAR,     ONE_Q16,       32'h0000_0000, 1'b0, ZERO_POINT},
    '{TO_POLAR,     32'h0000_0000, ONE_Q16,       1'b0, ZERO_POINT},
    '{TO_POLAR,     -ONE_Q16,      32'h0000_0000, 1'b0, ZERO_POINT},
    '{TO_POLAR,     32'h0000_0000, -ONE_Q16,      1'b0, ZERO_POINT},
    // just below the x axis: angles just above pi and just under 2pi
    '{TO_POLAR,     -ONE_Q16,      32'hFFFF_FFFF, 1'b0, ZERO_POINT},
    '{TO_POLAR,     ONE_Q16,       32'hFFFF_FFFF, 1'b0, ZERO_POINT},
    // radius overflow corners
    '{TO_POLAR,     32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, ZERO_POINT},
    '{TO_POLAR,     32'h8000_0000, 32'h8000_0000, 1'b0, ZERO_POINT},
    '{TO_POLAR,     32'h8000_0000, 32'h0000_0000, 1'b0, ZERO_POINT},
    '{TO_POLAR,     32'h7FFF_FFFF, 32'h8000_0000, 1'b0, ZERO_POINT},
    // smallest non-zero x
    '{TO_POLAR,     32'h0000_0001, 32'h0000_0000, 1'b0, ZERO_POINT}
  };

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // atan(2^-i) in Q.30: alternating series summed in Q.60, rounded half up.
  function automatic longint arctan_q30(int i);
    longint unsigned sum;
    longint unsigned term;
    int              k;
    if (i == 0) return QUARTER_PI_Q30;
    sum = 0;
    for (k = 0; i * (2 * k + 1) <= 60; k++) begin
      term = (64'd1 << (60 - i * (2 * k + 1))) / (2 * k + 1);
      if (k % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    return longint'((sum + (64'd1 << 29)) >> 30);
  endfunction

  // Clamp to the signed 32-bit range, flagging any clamp.
  function automatic logic [31:0] clamp_s32(longint v, inout logic clamped);
    if (v > 64'sd2147483647) begin
      clamped = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      clamped = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // Rotation: radius and angle to x, y.
  function automatic conv_result_t rotate_to_cartesian(logic signed [31:0] radius,
                                                       logic signed [31:0] angle);
    longint       r, z, x, y, dx, dy, xr, yr, gain;
    logic         flip;
    logic         clamped;
    conv_result_t res;
    r = radius;
    z = angle;
    z = z * 4;
    gain = GAIN_Q32;
    flip = 1'b0;
    clamped = 1'b0;
    // reduce into [-pi, pi), then fold into [-pi/2, pi/2]
    if (z >= PI_Q30) z -= PI2_Q30;
    if (z >= PI_Q30) z -= PI2_Q30;
    if (z < -PI_Q30) z += PI2_Q30;
    if (z < -PI_Q30) z += PI2_Q30;
    if (z > HALF_PI_Q30) begin
      z -= PI_Q30;
      flip = 1'b1;
    end else if (z < -HALF_PI_Q30) begin
      z += PI_Q30;
      flip = 1'b1;
    end
    x = (r * gain + 32768) >>> 16;
    y = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= arctan_q30(i);
      end else begin
        x += dx;
        y -= dy;
        z += arctan_q30(i);
      end
    end
    xr = (x + 32768) >>> 16;
    yr = (y + 32768) >>> 16;
    if (flip) begin
      xr = -xr;
      yr = -yr;
    end
    res.a = clamp_s32(xr, clamped);
    res.b = clamp_s32(yr, clamped);
    res.sat = clamped;
    return res;
  endfunction

  // Vectoring: x, y to radius and angle in [0, 2pi).
  function automatic conv_result_t vector_to_polar(logic signed [31:0] xin,
                                                   logic signed [31:0] yin);
    longint          x, y, z, dx, dy, ang;
    longint unsigned ux, p, rad;
    conv_result_t    res;
    res = '0;
    // origin: nothing to measure, answer zero
    if (xin == 0 && yin == 0) return res;
    x = xin;
    x = x * 65536;
    y = yin;
    y = y * 65536;
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      if (yin >= 0) z = PI_Q30;
      else z = -PI_Q30;
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += arctan_q30(i);
      end else begin
        x -= dx;
        y += dy;
        z -= arctan_q30(i);
      end
    end
    if (x < 0) x = 0;
    ux = x;
    p = (ux >> 16) * GAIN_Q32 + (((ux & 64'hFFFF) * GAIN_Q32) >> 16);
    rad = (p + 64'h8000_0000) >> 32;
    if (rad > 64'h7FFF_FFFF) begin
      rad = 64'h7FFF_FFFF;
      res.sat = 1'b1;
    end
    // hold the angle inside the half plane that the sign of y names
    if (yin >= 0) begin
      ang = z;
      if (ang < 0) ang = 0;
      if (ang > PI_Q30) ang = PI_Q30;
    end else begin
      ang = z + PI2_Q30;
      if (ang < PI_Q30) ang = PI_Q30;
      if (ang > PI2_Q30 - 1) ang = PI2_Q30 - 1;
    end
    ang = (ang + 2) / 4;
    if (ang > longint'(PI2_Q28) - 1) ang = longint'(PI2_Q28) - 1;
    res.a = rad[31:0];
    res.b = ang[31:0];
    return res;
  endfunction

  function automatic conv_result_t convert_point(conv_mode_t mode, logic [31:0] a,
                                                 logic [31:0] b);
    if (mode == TO_CARTESIAN) return rotate_to_cartesian(a, b);
    return vector_to_polar(a, b);
  endfunction

  // Random coordinate: full range, small magnitudes, corner values and zero.
  function automatic logic [31:0] random_coord();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 5))
      0, 1: ;
      2, 3: v = $signed(v) >>> $urandom_range(8, 31);
      4: begin
        case (v[2:0])
          3'd0:    v = 32'h7FFF_FFFF;
          3'd1:    v = 32'h8000_0000;
          3'd2:    v = 32'h0000_0001;
          3'd3:    v = 32'hFFFF_FFFF;
          3'd4:    v = ONE_Q16;
          default: v = -ONE_Q16;
        endcase
      end
      default: v = '0;
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, stimulus, result side
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Drive one item at the falling edge and hold it until the block takes it.
  // An idle burst may go in front of it; the payload is scrambled meanwhile.
  task automatic send_point(point_row_t row);
    if ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      point_if.valid   = 1'b0;
      point_if.mode    = 1'($urandom);
      point_if.coord_a = $urandom;
      point_if.coord_b = $urandom;
      repeat ($urandom_range(0, 16)) @(negedge clk);
    end
    @(negedge clk);
    point_if.valid   = 1'b1;
    point_if.mode    = row.mode;
    point_if.coord_a = row.a;
    point_if.coord_b = row.b;
    next_due = row.known ? row.res : convert_point(row.mode, row.a, row.b);
    do @(posedge clk); while (!point_if.ready);
  endtask

  // Main sequence: reset, directed table, random segments, drain, verdict.
  initial begin
    point_row_t row;
    rst = 1'b1;
    point_if.valid   = 1'b0;
    point_if.mode    = 1'b0;
    point_if.coord_a = '0;
    point_if.coord_b = '0;
    next_due = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) send_point(directed_rows[i]);

    // Hold the input until every directed item has come back.
    @(negedge clk);
    point_if.valid = 1'b0;
    while (results_due.size() != 0) @(posedge clk);

    // Random segments of 50 items, each with its own idling intensity.
    // The last two run flat out with no idling on either side.
    for (int seg = 0; seg < 12; seg++) begin
      if (seg >= 10) begin
        idle_pct = 0;
      end else begin
        case ($urandom_range(0, 3))
          0:       idle_pct = 0;
          1:       idle_pct = 10;
          2:       idle_pct = 30;
          default: idle_pct = 70;
        endcase
      end
      // Before the sixth segment, drop valid and let the pipeline empty again.
      if (seg == 5) begin
        @(negedge clk);
        point_if.valid = 1'b0;
        while (results_due.size() != 0) @(posedge clk);
      end
      for (int n = 0; n < 50; n++) begin
        row.mode  = conv_mode_t'(1'($urandom));
        row.a     = random_coord();
        row.b     = random_coord();
        row.known = 1'b0;
        row.res   = '0;
        // drop in the origin now and then
        if ($urandom_range(0, 31) == 0) begin
          row.a = '0;
          row.b = '0;
        end
        send_point(row);
      end
    end

    @(negedge clk);
    point_if.valid = 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Result side: ready high, broken by stall bursts while idling is on.
  initial begin
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_pct != 0 && $urandom_range(0, 399) < idle_pct) begin
        result_if.ready = 1'b0;
        repeat ($urandom_range(0, 16)) @(negedge clk);
      end else begin
        result_if.ready = 1'b1;
      end
    end
  end

  // Sample both channels at the rising edge: queue the prediction for each
  // accepted item, check each accepted result against the oldest one.
  always @(posedge clk) begin
    conv_result_t want;
    if (!rst) begin
      if (result_if.valid && result_if.ready) begin
        if (results_due.size() == 0) begin
          errors++;
          $error("result with none due: out_a %h out_b %h saturated %b",
                 result_if.out_a, result_if.out_b, result_if.saturated);
        end else begin
          want = results_due.pop_front();
          if (result_if.out_a !== want.a) begin
            errors++;
            $error("out_a: expected %h, got %h", want.a, result_if.out_a);
          end
          if (result_if.out_b !== want.b) begin
            errors++;
            $error("out_b: expected %h, got %h", want.b, result_if.out_b);
          end
          if (result_if.saturated !== want.sat) begin
            errors++;
            $error("saturated: expected %b, got %b", want.sat, result_if.saturated);
          end
        end
      end
      if (point_if.valid && point_if.ready) results_due.push_back(next_due);
      if ((point_if.valid && point_if.ready) || (result_if.valid && result_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  // Watchdog: too long without any handshake means the block has hung.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== polar_cartesian_converter_core.f =====
design/pcc_pkg.sv
design/pcc_in_if.sv
design/pcc_out_if.sv
design/pcc_cordic_stage.sv
design/polar_cartesian_converter_core.sv
bench/testbench.sv
